>>> sv/emgbp_pkg.sv
// shared types, widths and filter coefficients for the emg band-pass envelope block
package emgbp_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int FILT_W        = 13;
  localparam int MAG_W         = 13;
  localparam int ENV_W         = 14;
  localparam int USIZE_W       = 8;
  localparam int USUM_W        = 21;
  localparam int COEF_W        = 17;
  localparam int DLY_W         = 26;
  localparam int FRAC_W        = 14;
  localparam int IN_SHIFT      = 10;
  localparam int PROD_W        = COEF_W + DLY_W;
  localparam int ACC_W         = 45;
  localparam int MAX_SECTIONS  = 8;
  localparam int MSEC_W        = 3;

  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int SECTIONS_DEF     = 4;

  localparam logic [USIZE_W-1:0] USIZE_RST = 8'd10;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FBK,
    ST_FWD,
    ST_WIN,
    ST_DIV_ENV,
    ST_DIV_UNIT,
    ST_DONE
  } st_e;

  typedef enum logic [2:0] {
    TERM_A1,
    TERM_A2,
    TERM_B0,
    TERM_B1,
    TERM_B2
  } term_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } coef_t;

  // alternating lowpass and highpass sections (two of each), then pass-through sections
  localparam coef_t COEFS [MAX_SECTIONS] = '{
    '{ 17'sd845,    17'sd5955,  17'sd304,   17'sd608,    17'sd304  },
    '{ -17'sd8838,  17'sd6515,  17'sd16384, -17'sd32768, 17'sd16384 },
    '{ 17'sd7753,   17'sd11591, 17'sd16384, 17'sd32768,  17'sd16384 },
    '{ -17'sd16419, 17'sd12209, 17'sd16384, -17'sd32768, 17'sd16384 },
    '{ 17'sd0,      17'sd0,     17'sd16384, 17'sd0,      17'sd0     },
    '{ 17'sd0,      17'sd0,     17'sd16384, 17'sd0,      17'sd0     },
    '{ 17'sd0,      17'sd0,     17'sd16384, 17'sd0,      17'sd0     },
    '{ 17'sd0,      17'sd0,     17'sd16384, 17'sd0,      17'sd0     }
  };

endpackage

>>> sv/emgbp_ram.sv
// generic single-write, single-read ram with registered read data
module emgbp_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/emg_bandpass_envelope.sv
// emg band-pass biquad cascade with moving-average envelope and unit averaging
//
// Each accepted sample runs through SECTIONS biquad sections on one shared 17x26 multiplier
// (multiply and accumulate in alternate cycles), then updates a WINDOW_DEPTH-entry window
// held in a ram. The window mean is a multiply by the constant reciprocal of WINDOW_DEPTH.
// At the end of a unit one bit-serial restoring divider forms the unit average over DIV_W
// bits, the unit sum width (21 bits). A finished sample waits while the output register is
// full and the receiver has not taken it. The input is not ready while a sample is in work;
// a finished result waits in the output register while the next sample is taken. After
// reset the window ram is cleared one entry per cycle before the first sample is taken.
module emg_bandpass_envelope
  import emgbp_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int SECTIONS     = SECTIONS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [USIZE_W-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_W-1:0]      sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [FILT_W-1:0] filtered_o,
  output logic [ENV_W-1:0]         envelope_o,
  output logic [ENV_W-1:0]         unit_average_o,
  output logic                     unit_done_o
);

  localparam int WPTR_W = $clog2(WINDOW_DEPTH);
  localparam int WSUM_W = $clog2(WINDOW_DEPTH * (1 << (MAG_W - 1)) + 1);
  localparam int DIV_W  = USUM_W;
  localparam int DVS_W  = USIZE_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int RND_W  = ACC_W - FRAC_W;
  localparam int XD_W   = RND_W + 1;
  localparam int VABS_W = DLY_W + 1;
  localparam int FMAG_W = VABS_W - IN_SHIFT;
  localparam int RCP_SH = WSUM_W + WPTR_W;
  localparam int RCP_W  = WSUM_W + 1;
  localparam int EPRD_W = WSUM_W + RCP_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_W - 1));
  localparam logic signed [XD_W-1:0]  DLY_MAX  = XD_W'((1 << (DLY_W - 1)) - 1);
  localparam logic signed [XD_W-1:0]  DLY_MIN  = -XD_W'(1 << (DLY_W - 1));
  localparam logic [FMAG_W-1:0]       POS_LIM  = FMAG_W'((1 << (FILT_W - 1)) - 1);
  localparam logic [FMAG_W-1:0]       NEG_LIM  = FMAG_W'(1 << (FILT_W - 1));

  // ceiling reciprocal of the window depth, exact floor quotient for any window sum
  localparam longint RCP_VAL = ((longint'(1) << RCP_SH) + longint'(WINDOW_DEPTH) - 64'sd1)
                               / longint'(WINDOW_DEPTH);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [XD_W-1:0] v);
    logic signed [DLY_W-1:0] r;
    if (v > DLY_MAX) begin
      r = DLY_MAX[DLY_W-1:0];
    end else if (v < DLY_MIN) begin
      r = DLY_MIN[DLY_W-1:0];
    end else begin
      r = v[DLY_W-1:0];
    end
    return r;
  endfunction

  st_e   state_q, state_d;
  term_e term_q;

  logic [SEC_W-1:0]         sec_q;
  logic signed [DLY_W-1:0]  z1_q [SECTIONS];
  logic signed [DLY_W-1:0]  z2_q [SECTIONS];
  logic signed [DLY_W-1:0]  v_q;
  logic signed [DLY_W-1:0]  x_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [WPTR_W-1:0]  ptr_q;
  logic [WPTR_W-1:0]  clr_cnt_q;
  logic [WSUM_W-1:0]  wsum_q;
  logic [USIZE_W-1:0] unit_size_q;
  logic [USIZE_W-1:0] unit_count_q;
  logic [USUM_W-1:0]  unit_sum_q;

  logic [DIV_W-1:0]   div_quo_q;
  logic [DVS_W-1:0]   div_rem_q;
  logic [DVS_W-1:0]   div_dvs_q;
  logic [DCNT_W-1:0]  div_cnt_q;

  logic signed [FILT_W-1:0] filt_q;
  logic [ENV_W-1:0]         env_q;
  logic [ENV_W-1:0]         avg_q;
  logic                     done_q;

  logic                     out_valid_q;
  logic signed [FILT_W-1:0] out_filt_q;
  logic [ENV_W-1:0]         out_env_q;
  logic [ENV_W-1:0]         out_avg_q;
  logic                     out_done_q;

  // ram control
  logic              ram_we;
  logic [WPTR_W-1:0] ram_waddr;
  logic [MAG_W-1:0]  ram_wdata;
  logic [MAG_W-1:0]  ram_rdata;

  emgbp_ram #(
    .WIDTH(MAG_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  // shared multiplier operand selection
  coef_t                    coef_row;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [DLY_W-1:0]  opnd_sel;
  logic signed [DLY_W-1:0]  z1_cur;
  logic signed [DLY_W-1:0]  z2_cur;

  assign coef_row = COEFS[MSEC_W'(sec_q)];
  assign z1_cur   = z1_q[sec_q];
  assign z2_cur   = z2_q[sec_q];

  always_comb begin
    unique case (term_q)
      TERM_A1: begin
        coef_sel = coef_row.a1;
        opnd_sel = z1_cur;
      end
      TERM_A2: begin
        coef_sel = coef_row.a2;
        opnd_sel = z2_cur;
      end
      TERM_B0: begin
        coef_sel = coef_row.b0;
        opnd_sel = x_q;
      end
      TERM_B1: begin
        coef_sel = coef_row.b1;
        opnd_sel = z1_cur;
      end
      TERM_B2: begin
        coef_sel = coef_row.b2;
        opnd_sel = z2_cur;
      end
      default: begin
        coef_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  // rounding and saturation of the accumulator
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [RND_W-1:0] rnd;
  logic signed [XD_W-1:0]  xdiff;
  logic signed [DLY_W-1:0] x_new;
  logic signed [DLY_W-1:0] y_new;

  assign acc_rnd = acc_q + RND_HALF;
  assign rnd     = acc_rnd[ACC_W-1:FRAC_W];
  assign xdiff   = XD_W'(v_q) - XD_W'(rnd);
  assign x_new   = sat_dly(xdiff);
  assign y_new   = sat_dly(XD_W'(rnd));

  // cascade output truncated toward zero and saturated
  logic                     v_neg;
  logic signed [VABS_W-1:0] v_ext;
  logic [VABS_W-1:0]        v_abs;
  logic [FMAG_W-1:0]        f_mag;
  logic [MAG_W-1:0]         mag;
  logic signed [FILT_W-1:0] filt_c;

  assign v_neg = v_q[DLY_W-1];
  assign v_ext = VABS_W'(v_q);
  assign v_abs = v_neg ? VABS_W'(-v_ext) : VABS_W'(v_ext);
  assign f_mag = v_abs[VABS_W-1:IN_SHIFT];

  always_comb begin
    if (v_neg) begin
      mag = (f_mag > NEG_LIM) ? NEG_LIM[MAG_W-1:0] : f_mag[MAG_W-1:0];
    end else begin
      mag = (f_mag > POS_LIM) ? POS_LIM[MAG_W-1:0] : f_mag[MAG_W-1:0];
    end
  end

  assign filt_c = v_neg ? FILT_W'(MAG_W'(0) - mag) : FILT_W'(mag);

  // window and unit bookkeeping
  logic [WSUM_W-1:0]  wsum_d;
  logic [EPRD_W-1:0]  env_prod;
  logic [USUM_W-1:0]  usum_new;
  logic [USIZE_W-1:0] ucount_new;
  logic [USIZE_W-1:0] usize_eff;
  logic [ENV_W-1:0]   env_c;
  logic               unit_hit;

  assign wsum_d     = wsum_q - WSUM_W'(ram_rdata) + WSUM_W'(mag);
  // window mean by reciprocal multiplication, doubled
  assign env_prod   = EPRD_W'(wsum_q) * EPRD_W'(RCP);
  assign env_c      = {env_prod[RCP_SH+ENV_W-2:RCP_SH], 1'b0};
  assign usum_new   = unit_sum_q + USUM_W'(env_c);
  assign ucount_new = unit_count_q + USIZE_W'(1);
  assign usize_eff  = (unit_size_q == '0) ? USIZE_W'(1) : unit_size_q;
  assign unit_hit   = (ucount_new >= usize_eff);

  // restoring divider step
  logic [DVS_W:0]   div_trial;
  logic             div_ge;
  logic [DVS_W-1:0] div_rem_nx;
  logic             div_busy;

  assign div_trial  = {div_rem_q, div_quo_q[DIV_W-1]};
  assign div_ge     = (div_trial >= {1'b0, div_dvs_q});
  assign div_rem_nx = div_ge ? DVS_W'(div_trial - {1'b0, div_dvs_q}) : div_trial[DVS_W-1:0];
  assign div_busy   = (div_cnt_q != DCNT_W'(DIV_W));

  logic in_fire;
  logic last_sec;
  logic out_load;

  assign in_fire  = in_valid_i && in_ready_o;
  assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == WPTR_W'(WINDOW_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (term_q == TERM_A2) begin
          state_d = ST_FBK;
        end else if (term_q == TERM_B2) begin
          state_d = ST_FWD;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_FBK: state_d = ST_MUL;
      ST_FWD: state_d = last_sec ? ST_WIN : ST_MUL;
      ST_WIN: state_d = ST_DIV_ENV;
      ST_DIV_ENV: state_d = unit_hit ? ST_DIV_UNIT : ST_DONE;
      ST_DIV_UNIT: begin
        if (!div_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = mag;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_WIN:  ram_we = 1'b1;
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control and model state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      term_q       <= TERM_A1;
      sec_q        <= '0;
      clr_cnt_q    <= '0;
      ptr_q        <= '0;
      wsum_q       <= '0;
      unit_size_q  <= USIZE_RST;
      unit_count_q <= '0;
      unit_sum_q   <= '0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        z1_q[i] <= '0;
        z2_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) unit_size_q <= cfg_wdata_i;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + WPTR_W'(1);

      if (in_fire) begin
        sec_q  <= '0;
        term_q <= TERM_A1;
      end

      if (state_q == ST_ACC) begin
        unique case (term_q)
          TERM_A1: term_q <= TERM_A2;
          TERM_B0: term_q <= TERM_B1;
          TERM_B1: term_q <= TERM_B2;
          default: term_q <= term_q;
        endcase
      end

      if (state_q == ST_FBK) term_q <= TERM_B0;

      if (state_q == ST_FWD) begin
        z2_q[sec_q] <= z1_cur;
        z1_q[sec_q] <= x_q;
        term_q      <= TERM_A1;
        if (!last_sec) sec_q <= sec_q + SEC_W'(1);
      end

      if (state_q == ST_WIN) begin
        wsum_q <= wsum_d;
        ptr_q  <= (ptr_q == WPTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + WPTR_W'(1);
      end

      if ((state_q == ST_DIV_UNIT) && div_busy) div_cnt_q <= div_cnt_q + DCNT_W'(1);

      if (state_q == ST_DIV_ENV) begin
        div_cnt_q <= '0;
        if (unit_hit) begin
          unit_sum_q   <= '0;
          unit_count_q <= '0;
        end else begin
          unit_sum_q   <= usum_new;
          unit_count_q <= ucount_new;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q   <= DLY_W'({sample_i, IN_SHIFT'(0)});
      acc_q <= '0;
    end

    if (state_q == ST_MUL) prod_q <= coef_sel * opnd_sel;
    if (state_q == ST_ACC) acc_q <= acc_q + ACC_W'(prod_q);

    if (state_q == ST_FBK) begin
      x_q   <= x_new;
      acc_q <= '0;
    end

    if (state_q == ST_FWD) begin
      v_q   <= y_new;
      acc_q <= '0;
    end

    if (state_q == ST_WIN) filt_q <= filt_c;

    if ((state_q == ST_DIV_UNIT) && div_busy) begin
      div_rem_q <= div_rem_nx;
      div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
    end

    if (state_q == ST_DIV_ENV) begin
      env_q  <= env_c;
      done_q <= unit_hit;
      avg_q  <= '0;
      if (unit_hit) begin
        div_quo_q <= DIV_W'(usum_new);
        div_rem_q <= '0;
        div_dvs_q <= DVS_W'(usize_eff);
      end
    end

    if ((state_q == ST_DIV_UNIT) && !div_busy) avg_q <= div_quo_q[ENV_W-1:0];

    if (out_load) begin
      out_filt_q <= filt_q;
      out_env_q  <= env_q;
      out_avg_q  <= avg_q;
      out_done_q <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_o     = out_filt_q;
  assign envelope_o     = out_env_q;
  assign unit_average_o = out_avg_q;
  assign unit_done_o    = out_done_q;

  // a taken sample keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  // average is zero unless the unit completed
  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_done_o |-> unit_average_o == '0)
    else $error("unit average nonzero without unit done");

  // a completed unit hands a fresh count to the divider
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_ENV && unit_hit |=> state_q == ST_DIV_UNIT && div_cnt_q == '0)
    else $error("divider not restarted for the unit average");

  // during the unit division the unit counter and unit sum are already cleared
  a_unit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_UNIT |-> unit_count_q == '0 && unit_sum_q == '0)
    else $error("unit state not cleared on unit completion");

endmodule
